>>> design/odo_pkg.sv
// odometry package: shared types, fixed-point constants and small helper functions
// used by every file of the odometry block; depends on nothing
package odo_pkg;

	localparam int unsigned CORDIC_STEPS_DEF = 24;
	localparam int unsigned CFG_W = 31;

	localparam logic [CFG_W-1:0] SPACING_RST = 31'd36438;
	localparam logic [CFG_W-1:0] CIRC_RST = 31'd39716;

	// angles are radians scaled by 2^29
	localparam logic signed [63:0] ANG_PI = 64'sd1686629713;
	localparam logic signed [63:0] ANG_TWO_PI = 64'sd3373259426;
	localparam logic signed [63:0] ANG_HALF_PI = 64'sd843314857;
	localparam logic signed [63:0] Q29_ONE = 64'sd536870912;
	localparam logic signed [63:0] THETA_CLAMP = 64'sd562949953421312;
	localparam logic signed [63:0] DEG_FULL = 64'sd360;
	localparam logic signed [63:0] MEGA = 64'sd1000000;
	localparam logic signed [63:0] TURN_SCALE = 64'sd15625;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd326016437;

	typedef enum logic [1:0] {
		MD_MUL,
		MD_DIVR,
		MD_UMOD
	} md_op_t;

	typedef struct packed {
		logic   start;
		md_op_t op;
	} md_req_t;

	typedef enum logic {
		REG_SPACING = 1'b0,
		REG_CIRC    = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_OUT
	} state_t;

	typedef enum logic [4:0] {
		S_DL_MUL, S_DL_DIV, S_DR_MUL, S_DR_DIV, S_TH_DIV,
		S_TW_MOD, S_TW_COR, S_DX_MUL, S_DX_DIV, S_DY_MUL,
		S_DY_DIV, S_DX_STR, S_H_COR, S_WX_M1, S_WX_M2,
		S_WX_DIV, S_WY_M1, S_WY_M2, S_WY_DIV, S_HD_MOD,
		S_VX_MUL, S_VX_DIV, S_VY_MUL, S_VY_DIV, S_VL_MUL,
		S_VL_DIV, S_VR_MUL, S_VR_DIV, S_VT_MUL, S_VT_DIV,
		S_DONE
	} step_t;

	function automatic logic [31:0] atan_q29(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0: v = 32'd421657428;
			5'd1: v = 32'd248918915;
			5'd2: v = 32'd131521918;
			5'd3: v = 32'd66762579;
			5'd4: v = 32'd33510843;
			5'd5: v = 32'd16771758;
			5'd6: v = 32'd8387925;
			5'd7: v = 32'd4194219;
			5'd8: v = 32'd2097141;
			5'd9: v = 32'd1048575;
			5'd10: v = 32'd524288;
			5'd11: v = 32'd262144;
			5'd12: v = 32'd131072;
			5'd13: v = 32'd65536;
			5'd14: v = 32'd32768;
			5'd15: v = 32'd16384;
			5'd16: v = 32'd8192;
			5'd17: v = 32'd4096;
			5'd18: v = 32'd2048;
			5'd19: v = 32'd1024;
			5'd20: v = 32'd512;
			5'd21: v = 32'd256;
			5'd22: v = 32'd128;
			5'd23: v = 32'd64;
			5'd24: v = 32'd32;
			5'd25: v = 32'd16;
			5'd26: v = 32'd8;
			5'd27: v = 32'd4;
			5'd28: v = 32'd2;
			5'd29: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

>>> design/odo_muldiv.sv
// shared 64-bit multiply / divide / modulo unit, one bit per cycle over one adder
// multiply keeps the low 64 bits, divide rounds halves away from zero; uses odo_pkg
module odo_muldiv import odo_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  md_req_t            req,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic               done,
	output logic [63:0]        result
);

	logic        run_q, fin_q;
	logic [5:0]  cnt_q;
	md_op_t      op_q;
	logic [63:0] x_q, y_q;
	logic [64:0] acc_q;
	logic        neg_q, zero_q;
	logic [63:0] abs_a, abs_b, y_init;
	logic [64:0] rem_sh, add_a, add_b, add_sum;
	logic        add_sub;

	always_comb begin
		abs_a = a[63] ? 64'd0 - 64'(a) : 64'(a);
		abs_b = b[63] ? 64'd0 - 64'(b) : 64'(b);
		y_init = abs_a + {1'b0, abs_b[63:1]};
		rem_sh = {acc_q[63:0], y_q[63]};
		if (op_q == MD_MUL) begin
			add_a = acc_q;
			add_sub = 1'b0;
		end else begin
			add_a = rem_sh;
			add_sub = 1'b1;
		end
		add_b = {1'b0, x_q};
		add_sum = add_a + (add_sub ? ~add_b : add_b) + 65'(add_sub);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q <= req.op;
			acc_q <= '0;
			neg_q <= a[63] ^ b[63];
			zero_q <= (b == '0);
			case (req.op)
				MD_MUL: begin
					x_q <= 64'(a);
					y_q <= 64'(b);
				end
				MD_DIVR: begin
					x_q <= abs_b;
					y_q <= y_init;
				end
				default: begin
					x_q <= 64'(b);
					y_q <= 64'(a);
				end
			endcase
		end else if (run_q) begin
			if (op_q == MD_MUL) begin
				if (y_q[0]) begin
					acc_q <= {1'b0, add_sum[63:0]};
				end
				x_q <= {x_q[62:0], 1'b0};
				y_q <= {1'b0, y_q[63:1]};
			end else begin
				// restoring step: keep the difference when no borrow
				if (!add_sum[64]) begin
					acc_q <= add_sum;
					y_q <= {y_q[62:0], 1'b1};
				end else begin
					acc_q <= rem_sh;
					y_q <= {y_q[62:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		case (op_q)
			MD_MUL: result = acc_q[63:0];
			MD_DIVR: result = zero_q ? 64'd0 : (neg_q ? 64'd0 - y_q : y_q);
			default: result = acc_q[63:0];
		endcase
	end

	assign done = fin_q;

endmodule

>>> design/odo_cordic.sv
// iterative rotation-mode cordic, one micro-rotation per cycle
// folds angles beyond half pi and negates the results; uses odo_pkg
module odo_cordic import odo_pkg::*; #(
	parameter int unsigned STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [33:0] angle,
	output logic               done,
	output logic signed [33:0] cos_o,
	output logic signed [33:0] sin_o
);

	localparam logic [5:0] LAST = 6'(STEPS - 1);
	localparam logic signed [33:0] HALF = 34'(ANG_HALF_PI);
	localparam logic signed [33:0] PI34 = 34'(ANG_PI);

	logic               run_q, fin_q, flip_q;
	logic [5:0]         i_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic signed [33:0] x_sh, y_sh, at;

	always_comb begin
		x_sh = x_q >>> i_q[4:0];
		y_sh = y_q >>> i_q[4:0];
		at = $signed({2'b00, atan_q29(i_q[4:0])});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			i_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				i_q <= '0;
			end else if (run_q) begin
				i_q <= i_q + 6'd1;
				if (i_q == LAST) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			if (angle > HALF) begin
				z_q <= angle - PI34;
				flip_q <= 1'b1;
			end else if (angle < -HALF) begin
				z_q <= angle + PI34;
				flip_q <= 1'b1;
			end else begin
				z_q <= angle;
				flip_q <= 1'b0;
			end
		end else if (run_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + at;
			end
		end
	end

	assign cos_o = flip_q ? -x_q : x_q;
	assign sin_o = flip_q ? -y_q : y_q;
	assign done = fin_q;

endmodule

>>> design/diff_drive_odometry.sv
// differential-drive odometry top level: sequencer, pose state and result register
// depends on odo_pkg, odo_muldiv and odo_cordic
//
//  channel | signals                                        | dir | handshake
//  in      | left_angle, right_angle, elapsed_us            | in  | in_valid / in_stall
//  out     | pos_x, pos_y, heading, speed_x, speed_y,       | out | out_valid / out_stall
//          | turn_rate, left_speed, right_speed, rate_invalid|     |
//  cfg     | cfg_index, cfg_data                            | in  | cfg_we, no wait
//
// one request takes up to 27 passes through the multiply/divide unit, each an issue,
// 64 steps and a done, and two cordic runs of CORDIC_STEPS micro-rotations, plus the
// idle and output states; zero elapsed_us skips the speed steps, and a straight step
// replaces the turn fold, its cordic run and the chord steps with one divide
// the multiply/divide unit dominates the time; in_stall is high from acceptance until the
// result is loaded into the output register
// a waiting result does not block the next request; only loading the new result waits
// reset clears the pose, the previous angles and sets the registers to their defaults
module diff_drive_odometry import odo_pkg::*; #(
	parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] left_angle,
	input  logic signed [31:0] right_angle,
	input  logic [23:0]        elapsed_us,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] heading,
	output logic signed [31:0] speed_x,
	output logic signed [31:0] speed_y,
	output logic signed [31:0] turn_rate,
	output logic signed [31:0] left_speed,
	output logic signed [31:0] right_speed,
	output logic               rate_invalid,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	state_t state_q, state_d;
	step_t  step_q, step_d;

	logic [CFG_W-1:0]   spacing_q, circ_q;
	logic signed [31:0] last_l_q, last_r_q, acc_x_q, acc_y_q, acc_h_q;
	logic signed [31:0] l_q, r_q, dl_q, dr_q, tw_q;
	logic [23:0]        us_q;
	logic signed [63:0] theta_q, s_q, dx_q, dy_q, t1_q, tmp_q;
	logic signed [33:0] c_q, sn_q, ch_q, sh_q;
	logic signed [31:0] vx_q, vy_q, vt_q, vl_q, vr_q;

	logic               out_valid_q, out_rinv_q;
	logic signed [31:0] out_x_q, out_y_q, out_h_q, out_vx_q, out_vy_q, out_vt_q;
	logic signed [31:0] out_vl_q, out_vr_q;

	md_req_t            md_req;
	logic signed [63:0] md_a, md_b, md_res;
	logic [63:0]        md_result;
	logic               md_done;
	logic               cor_start, cor_done;
	logic signed [33:0] cor_angle, cor_cos, cor_sin;

	logic               accept, use_cor, unit_done, latch, out_load;
	logic signed [63:0] dl64, dr64, dleft, dright, spacing64, us64;
	logic signed [63:0] wrap_in, wrap_v, wrap_abs, wrap_m, tc;
	logic signed [31:0] wrap_out;

	odo_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.a      (md_a),
		.b      (md_b),
		.done   (md_done),
		.result (md_result)
	);

	odo_cordic #(.STEPS(CORDIC_STEPS)) u_cor (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.angle  (cor_angle),
		.done   (cor_done),
		.cos_o  (cor_cos),
		.sin_o  (cor_sin)
	);

	always_comb begin
		md_res = $signed(md_result);
		dl64 = 64'(dl_q);
		dr64 = 64'(dr_q);
		dleft = 64'(l_q) - 64'(last_l_q);
		dright = 64'(r_q) - 64'(last_r_q);
		spacing64 = (spacing_q == '0) ? 64'sd1 : $signed(64'(spacing_q));
		us64 = $signed(64'(us_q));
		// the heading update and the theta fold share the modulo path
		wrap_in = (step_q == S_HD_MOD) ? 64'(acc_h_q) + 64'(tw_q) : theta_q;
		wrap_v = wrap_in + ANG_PI;
		wrap_abs = wrap_v[63] ? -wrap_v : wrap_v;
		if (!wrap_v[63]) begin
			wrap_m = md_res;
		end else begin
			wrap_m = (md_res == '0) ? 64'sd0 : ANG_TWO_PI - md_res;
		end
		wrap_out = 32'(wrap_m - ANG_PI);
		if (theta_q > THETA_CLAMP) begin
			tc = THETA_CLAMP;
		end else if (theta_q < -THETA_CLAMP) begin
			tc = -THETA_CLAMP;
		end else begin
			tc = theta_q;
		end
	end

	// operand selection per step
	always_comb begin
		md_req.op = MD_MUL;
		md_a = '0;
		md_b = '0;
		cor_angle = '0;
		use_cor = 1'b0;
		case (step_q)
			S_DL_MUL: begin
				md_a = dleft;
				md_b = $signed(64'(circ_q));
			end
			S_DR_MUL: begin
				md_a = dright;
				md_b = $signed(64'(circ_q));
			end
			S_DL_DIV, S_DR_DIV: begin
				md_req.op = MD_DIVR;
				md_a = tmp_q;
				md_b = DEG_FULL;
			end
			S_TH_DIV: begin
				md_req.op = MD_DIVR;
				md_a = (dr64 - dl64) <<< 29;
				md_b = spacing64;
			end
			S_TW_MOD, S_HD_MOD: begin
				md_req.op = MD_UMOD;
				md_a = wrap_abs;
				md_b = ANG_TWO_PI;
			end
			S_TW_COR: begin
				use_cor = 1'b1;
				cor_angle = 34'(tw_q);
			end
			S_H_COR: begin
				use_cor = 1'b1;
				cor_angle = 34'(acc_h_q);
			end
			S_DX_MUL: begin
				md_a = s_q;
				md_b = 64'(sn_q);
			end
			S_DY_MUL: begin
				md_a = s_q;
				md_b = Q29_ONE - 64'(c_q);
			end
			S_DX_DIV, S_DY_DIV: begin
				md_req.op = MD_DIVR;
				md_a = tmp_q;
				md_b = theta_q <<< 1;
			end
			S_DX_STR: begin
				md_req.op = MD_DIVR;
				md_a = s_q;
				md_b = 64'sd2;
			end
			S_WX_M1, S_WY_M2: begin
				md_a = 64'(ch_q);
				md_b = (step_q == S_WX_M1) ? dx_q : dy_q;
			end
			S_WX_M2, S_WY_M1: begin
				md_a = 64'(sh_q);
				md_b = (step_q == S_WY_M1) ? dx_q : dy_q;
			end
			S_WX_DIV: begin
				md_req.op = MD_DIVR;
				md_a = t1_q - tmp_q;
				md_b = Q29_ONE;
			end
			S_WY_DIV: begin
				md_req.op = MD_DIVR;
				md_a = t1_q + tmp_q;
				md_b = Q29_ONE;
			end
			S_VX_MUL: begin
				md_a = dx_q;
				md_b = MEGA;
			end
			S_VY_MUL: begin
				md_a = dy_q;
				md_b = MEGA;
			end
			S_VL_MUL: begin
				md_a = dl64;
				md_b = MEGA;
			end
			S_VR_MUL: begin
				md_a = dr64;
				md_b = MEGA;
			end
			S_VT_MUL: begin
				md_a = tc;
				md_b = TURN_SCALE;
			end
			S_VX_DIV, S_VY_DIV, S_VL_DIV, S_VR_DIV: begin
				md_req.op = MD_DIVR;
				md_a = tmp_q;
				md_b = us64;
			end
			S_VT_DIV: begin
				md_req.op = MD_DIVR;
				md_a = tmp_q;
				md_b = us64 <<< 7;
			end
			default: begin
				md_req.op = MD_MUL;
			end
		endcase
		md_req.start = (state_q == ST_ISSUE) && !use_cor;
		cor_start = (state_q == ST_ISSUE) && use_cor;
	end

	// next state and next step
	always_comb begin
		unit_done = use_cor ? cor_done : md_done;
		accept = in_valid && (state_q == ST_IDLE);
		latch = (state_q == ST_WAIT) && unit_done;
		out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
		in_stall = (state_q != ST_IDLE);
		state_d = state_q;
		step_d = step_q;
		case (step_q)
			S_DL_MUL: step_d = S_DL_DIV;
			S_DL_DIV: step_d = S_DR_MUL;
			S_DR_MUL: step_d = S_DR_DIV;
			S_DR_DIV: step_d = S_TH_DIV;
			S_TH_DIV: step_d = (md_res != '0) ? S_TW_MOD : S_DX_STR;
			S_TW_MOD: step_d = S_TW_COR;
			S_TW_COR: step_d = S_DX_MUL;
			S_DX_MUL: step_d = S_DX_DIV;
			S_DX_DIV: step_d = S_DY_MUL;
			S_DY_MUL: step_d = S_DY_DIV;
			S_DY_DIV: step_d = S_H_COR;
			S_DX_STR: step_d = S_H_COR;
			S_H_COR: step_d = S_WX_M1;
			S_WX_M1: step_d = S_WX_M2;
			S_WX_M2: step_d = S_WX_DIV;
			S_WX_DIV: step_d = S_WY_M1;
			S_WY_M1: step_d = S_WY_M2;
			S_WY_M2: step_d = S_WY_DIV;
			S_WY_DIV: step_d = S_HD_MOD;
			S_HD_MOD: step_d = (us_q != '0) ? S_VX_MUL : S_DONE;
			S_VX_MUL: step_d = S_VX_DIV;
			S_VX_DIV: step_d = S_VY_MUL;
			S_VY_MUL: step_d = S_VY_DIV;
			S_VY_DIV: step_d = S_VL_MUL;
			S_VL_MUL: step_d = S_VL_DIV;
			S_VL_DIV: step_d = S_VR_MUL;
			S_VR_MUL: step_d = S_VR_DIV;
			S_VR_DIV: step_d = S_VT_MUL;
			S_VT_MUL: step_d = S_VT_DIV;
			default: step_d = S_DONE;
		endcase
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: state_d = ST_WAIT;
			ST_WAIT: begin
				if (unit_done) begin
					state_d = (step_d == S_DONE) ? ST_OUT : ST_ISSUE;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= S_DL_MUL;
			spacing_q <= SPACING_RST;
			circ_q <= CIRC_RST;
			last_l_q <= '0;
			last_r_q <= '0;
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_h_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= S_DL_MUL;
			end else if (latch) begin
				step_q <= step_d;
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_SPACING: spacing_q <= cfg_data;
					REG_CIRC: circ_q <= cfg_data;
					default: ;
				endcase
			end
			if (latch) begin
				case (step_q)
					S_WX_DIV: acc_x_q <= acc_x_q + md_result[31:0];
					S_WY_DIV: acc_y_q <= acc_y_q + md_result[31:0];
					S_HD_MOD: acc_h_q <= wrap_out;
					default: ;
				endcase
			end
			if (out_load) begin
				last_l_q <= l_q;
				last_r_q <= r_q;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			l_q <= left_angle;
			r_q <= right_angle;
			us_q <= elapsed_us;
		end
		if (latch) begin
			case (step_q)
				S_DL_DIV: dl_q <= sat32(md_res);
				S_DR_DIV: dr_q <= sat32(md_res);
				S_TH_DIV: begin
					theta_q <= md_res;
					s_q <= dl64 + dr64;
					tw_q <= '0;
				end
				S_TW_MOD: tw_q <= wrap_out;
				S_TW_COR: begin
					c_q <= cor_cos;
					sn_q <= cor_sin;
				end
				S_H_COR: begin
					ch_q <= cor_cos;
					sh_q <= cor_sin;
				end
				S_DX_DIV: dx_q <= md_res;
				S_DY_DIV: dy_q <= md_res;
				S_DX_STR: begin
					dx_q <= md_res;
					dy_q <= '0;
				end
				S_WX_M1, S_WY_M1: t1_q <= md_res;
				S_HD_MOD: begin
					// zero elapsed time leaves every speed at zero
					vx_q <= '0;
					vy_q <= '0;
					vt_q <= '0;
					vl_q <= '0;
					vr_q <= '0;
				end
				S_VX_DIV: vx_q <= sat32(md_res);
				S_VY_DIV: vy_q <= sat32(md_res);
				S_VL_DIV: vl_q <= sat32(md_res);
				S_VR_DIV: vr_q <= sat32(md_res);
				S_VT_DIV: vt_q <= sat32(md_res);
				default: tmp_q <= md_res;
			endcase
		end
		if (out_load) begin
			out_x_q <= acc_x_q;
			out_y_q <= acc_y_q;
			out_h_q <= acc_h_q;
			out_vx_q <= vx_q;
			out_vy_q <= vy_q;
			out_vt_q <= vt_q;
			out_vl_q <= vl_q;
			out_vr_q <= vr_q;
			out_rinv_q <= (us_q == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x = out_x_q;
	assign pos_y = out_y_q;
	assign heading = out_h_q;
	assign speed_x = out_vx_q;
	assign speed_y = out_vy_q;
	assign turn_rate = out_vt_q;
	assign left_speed = out_vl_q;
	assign right_speed = out_vr_q;
	assign rate_invalid = out_rinv_q;

endmodule

>>> design/odo_chk.sv
// port-level checks for the odometry block, attached to the top level by bind
// depends on odo_pkg and diff_drive_odometry
module odo_chk import odo_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] pos_x,
	input logic signed [31:0] heading,
	input logic signed [31:0] speed_x,
	input logic signed [31:0] speed_y,
	input logic signed [31:0] turn_rate,
	input logic signed [31:0] left_speed,
	input logic signed [31:0] right_speed,
	input logic               rate_invalid
);

	localparam logic signed [31:0] PI32 = 32'(ANG_PI);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(heading))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while another is in work");

	a_zero_rate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rate_invalid |-> speed_x == 0 && speed_y == 0 && turn_rate == 0
			&& left_speed == 0 && right_speed == 0)
		else $error("speeds nonzero with zero elapsed time");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> heading >= -PI32 && heading < PI32)
		else $error("heading outside wrap range");

endmodule

bind diff_drive_odometry odo_chk u_odo_chk (.*);

>>> dv/tb.sv
// self-checking testbench for diff_drive_odometry: directed, configuration sweep,
// back-pressure and random odometry requests checked against an in-bench predictor
// depends on odo_pkg and the diff_drive_odometry rtl
module tb import odo_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int HOLD_CYCLES = 6000;
	localparam int TAIL_CYCLES = 2000;
	localparam longint PI_Q29 = 64'sd1686629713;
	localparam longint TWO_PI_Q29 = 64'sd3373259426;
	localparam longint HALF_PI_Q29 = 64'sd843314857;
	localparam longint ONE_Q29 = 64'sd536870912;
	localparam longint GAIN_Q29 = 64'sd326016437;
	localparam longint RATE_CLAMP = 64'sd562949953421312;
	localparam int N_ROT = 24;

	typedef struct {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] heading;
		logic signed [31:0] speed_x;
		logic signed [31:0] speed_y;
		logic signed [31:0] turn_rate;
		logic signed [31:0] left_speed;
		logic signed [31:0] right_speed;
		logic               rate_invalid;
	} pose_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] left_angle = '0;
	logic signed [31:0] right_angle = '0;
	logic [23:0] elapsed_us = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] pos_x, pos_y, heading, speed_x, speed_y, turn_rate;
	logic signed [31:0] left_speed, right_speed;
	logic rate_invalid;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;

	diff_drive_odometry u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.left_angle(left_angle), .right_angle(right_angle), .elapsed_us(elapsed_us),
		.out_valid(out_valid), .out_stall(out_stall),
		.pos_x(pos_x), .pos_y(pos_y), .heading(heading),
		.speed_x(speed_x), .speed_y(speed_y), .turn_rate(turn_rate),
		.left_speed(left_speed), .right_speed(right_speed), .rate_invalid(rate_invalid),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	longint unsigned spacing_q16 = 36438;
	longint unsigned circ_q16 = 39716;
	longint prev_left = 0;
	longint prev_right = 0;
	logic [31:0] pose_x = '0;
	logic [31:0] pose_y = '0;
	longint pose_heading = 0;

	pose_t pending_poses[$];
	int errors = 0;
	int requests_sent = 0;
	int poses_checked = 0;
	int zero_dt_requests = 0;
	int idle_cycles_total = 0;
	bit idle_on = 1'b1;
	logic hold_req = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	longint rot_table[32] = '{
		421657428, 248918915, 131521918, 66762579, 33510843, 16771758, 8387925,
		4194219, 2097141, 1048575, 524288, 262144, 131072, 65536, 32768, 16384,
		8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0
	};

	initial forever #10 clk = ~clk;

	function automatic longint div_nearest(longint n, longint d);
		longint unsigned un, ud, q;
		un = (n < 0) ? -n : n;
		ud = (d < 0) ? -d : d;
		if (ud == 0) begin
			return 0;
		end
		q = (un + ud / 2) / ud;
		return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint wrap_pi(longint a);
		longint m;
		m = (a + PI_Q29) % TWO_PI_Q29;
		if (m < 0) begin
			m += TWO_PI_Q29;
		end
		return m - PI_Q29;
	endfunction

	// rotation-mode sin/cos, input already in [-pi, pi)
	task automatic sin_cos(input longint a, output longint c, output longint s);
		longint x, y, z, nx;
		bit flip;
		x = GAIN_Q29;
		y = 0;
		z = a;
		flip = 1'b0;
		if (z > HALF_PI_Q29) begin
			z -= PI_Q29;
			flip = 1'b1;
		end else if (z < -HALF_PI_Q29) begin
			z += PI_Q29;
			flip = 1'b1;
		end
		for (int i = 0; i < N_ROT; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= rot_table[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += rot_table[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	task automatic predict_pose(input longint l, input longint r, input longint us,
			output pose_t p);
		longint spc, dl, dr, s, theta, tw, dx, dy, c, sn, ch, sh, wx, wy, tc;
		spc = (spacing_q16 != 0) ? longint'(spacing_q16) : 1;
		dl = clip32(div_nearest((l - prev_left) * longint'(circ_q16), 360));
		dr = clip32(div_nearest((r - prev_right) * longint'(circ_q16), 360));
		prev_left = l;
		prev_right = r;
		theta = div_nearest((dr - dl) * ONE_Q29, spc);
		s = dr + dl;
		tw = 0;
		if (theta != 0) begin
			tw = wrap_pi(theta);
			sin_cos(tw, c, sn);
			dx = div_nearest(s * sn, 2 * theta);
			dy = div_nearest(s * (ONE_Q29 - c), 2 * theta);
		end else begin
			dx = div_nearest(s, 2);
			dy = 0;
		end
		sin_cos(pose_heading, ch, sh);
		wx = div_nearest(ch * dx - sh * dy, ONE_Q29);
		wy = div_nearest(sh * dx + ch * dy, ONE_Q29);
		pose_x = pose_x + wx[31:0];
		pose_y = pose_y + wy[31:0];
		pose_heading = wrap_pi(pose_heading + tw);
		p.pos_x = pose_x;
		p.pos_y = pose_y;
		p.heading = pose_heading[31:0];
		p.rate_invalid = (us == 0);
		p.speed_x = '0;
		p.speed_y = '0;
		p.turn_rate = '0;
		p.left_speed = '0;
		p.right_speed = '0;
		if (us != 0) begin
			p.speed_x = 32'(clip32(div_nearest(dx * 1000000, us)));
			p.speed_y = 32'(clip32(div_nearest(dy * 1000000, us)));
			p.left_speed = 32'(clip32(div_nearest(dl * 1000000, us)));
			p.right_speed = 32'(clip32(div_nearest(dr * 1000000, us)));
			tc = theta;
			if (tc > RATE_CLAMP) tc = RATE_CLAMP;
			if (tc < -RATE_CLAMP) tc = -RATE_CLAMP;
			p.turn_rate = 32'(clip32(div_nearest(tc * 15625, 128 * us)));
		end
	endtask

	// one odometry request, held until accepted
	task automatic send_request(input logic signed [31:0] l, input logic signed [31:0] r,
			input logic [23:0] us);
		pose_t p;
		while (idle_on && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		left_angle <= l;
		right_angle <= r;
		elapsed_us <= us;
		do @(posedge clk); while (in_stall);
		predict_pose(longint'(l), longint'(r), longint'(us), p);
		pending_poses = {pending_poses, p};
		requests_sent++;
		if (us == 0) zero_dt_requests++;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_poses.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SPACING) spacing_q16 = 64'(val);
		else circ_q16 = 64'(val);
	endtask

	// mostly smooth wheel motion, some zero-time samples, straight-line steps and raw noise
	task automatic random_request;
		int pick;
		logic signed [31:0] l, r;
		logic [23:0] us;
		pick = $urandom_range(99);
		l = 32'(prev_left + longint'($urandom_range(6000)) - 3000);
		r = 32'(prev_right + longint'($urandom_range(6000)) - 3000);
		us = 24'($urandom_range(200000, 1));
		if (pick < 8) begin
			us = '0;
		end else if (pick < 12) begin
			r = 32'(longint'(l) - prev_left + prev_right);
		end else if (pick < 24) begin
			l = $urandom;
			r = $urandom;
			us = 24'($urandom);
		end
		send_request(l, r, us);
	endtask

	task automatic test_directed;
		send_request(0, 0, 24'd1000);
		send_request(360, 360, 24'd1000000);
		send_request(720, 0, 24'd20000);
		send_request(0, 720, 24'd0);
		send_request(-500, 900, 24'd1);
		send_request(32'sh7fffffff, 32'sh80000000, 24'hffffff);
		send_request(32'sh80000000, 32'sh7fffffff, 24'd1);
		send_request(32'sh80000000, 32'sh80000000, 24'd0);
		send_request(32'sh7fffffff, 32'sh7fffffff, 24'd5);
		send_request(0, 0, 24'hffffff);
		send_request(90, -90, 24'd50000);
		send_request(180, 0, 24'd50000);
		send_request(180, 1000, 24'd1);
		send_request(200, 1000, 24'd0);
		send_request(-1000000, 1000000, 24'd100);
		send_request(0, 0, 24'd0);
		drain();
	endtask

	task automatic test_config_sweep;
		logic [CFG_W-1:0] sp[5] = '{31'd1, 31'h7fffffff, 31'd0, 31'd20000, 31'd36438};
		logic [CFG_W-1:0] ci[5] = '{31'h7fffffff, 31'd1, 31'd0, 31'd65536, 31'd39716};
		for (int k = 0; k < 5; k++) begin
			write_reg(REG_SPACING, sp[k]);
			write_reg(REG_CIRC, ci[k]);
			send_request(32'sh7fffffff, 32'sh80000000, 24'd3);
			send_request(32'sh80000000, 32'sh7fffffff, 24'd0);
			for (int n = 0; n < 40; n++) random_request();
			drain();
		end
		write_reg(REG_SPACING, 31'($urandom));
		write_reg(REG_CIRC, 31'($urandom));
		for (int n = 0; n < 40; n++) random_request();
		drain();
		write_reg(REG_SPACING, 31'd36438);
		write_reg(REG_CIRC, 31'd39716);
	endtask

	// receiver holds off while requests keep coming, so the block backs up
	task automatic test_backpressure;
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		for (int n = 0; n < 6; n++) random_request();
		drain();
	endtask

	task automatic test_random(input int count, input bit with_idle);
		idle_on = with_idle;
		for (int n = 0; n < count; n++) random_request();
		drain();
		idle_on = 1'b1;
	endtask

	// receiver stall generation, with a counted hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= idle_on && ($urandom_range(99) < 29);
		end
		if (out_stall) idle_cycles_total++;
	end

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			errors++;
			if (errors <= 10) begin
				$display("mismatch %s: expected %0d actual %0d",
					name, $signed(want), $signed(got));
			end
		end
	endtask

	always @(posedge clk) begin
		pose_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_poses.size() == 0) begin
				errors++;
				if (errors <= 10) $display("pose result with no request waiting");
			end else begin
				e = pending_poses.pop_front();
				check_field("pos_x", pos_x, e.pos_x);
				check_field("pos_y", pos_y, e.pos_y);
				check_field("heading", heading, e.heading);
				check_field("speed_x", speed_x, e.speed_x);
				check_field("speed_y", speed_y, e.speed_y);
				check_field("turn_rate", turn_rate, e.turn_rate);
				check_field("left_speed", left_speed, e.left_speed);
				check_field("right_speed", right_speed, e.right_speed);
				check_field("rate_invalid", {31'd0, rate_invalid}, {31'd0, e.rate_invalid});
				poses_checked++;
			end
		end
	end

	// watchdog on cycles without any accepted request or result
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d quiet cycles", quiet_cycles);
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_backpressure();
		test_random(250, 1'b0);
		test_random(800, 1'b1);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_poses.size() != 0) begin
			errors++;
			$display("%0d expected poses never arrived", pending_poses.size());
		end
		$display("covered %0d requests (%0d with zero elapsed time), %0d poses checked",
			requests_sent, zero_dt_requests, poses_checked);
		$display("six register settings incl. zero and full scale, %0d receiver stall cycles",
			idle_cycles_total);
		if (errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end
endmodule
